// File: hdl/shp_pkg.sv
// Shared types and constants for the 3x3 cross sharpen stream.
`timescale 1ns / 1ps

package shp_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int RB_W     = 13;   // row_bytes register
  localparam int WID_W    = 12;   // width_px register
  localparam int ROW_W    = 16;   // height_rows register and row counters
  localparam int CFG_W    = 16;   // config write data
  localparam int REG_IDX_W = 2;

  // Line buffer geometry
  localparam int MAX_ROW_BYTES = 6144;
  localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
  localparam int TOTAL_W       = $clog2(MAX_ROW_BYTES * (2 ** ROW_W));
  localparam int MIN_STRIDE    = 3;

  // Kernel geometry: neighbors sit one pixel (three bytes) away
  localparam int PIX_BYTES = 3;
  localparam int CTR_TAP   = PIX_BYTES;
  localparam int TAP_SPAN  = 2 * PIX_BYTES + 1;
  localparam int CTR_GAIN  = 5;

  // Divide-by-three of the stride by reciprocal multiply
  localparam int THIRD_SH  = RB_W;
  localparam int THIRD_MUL = (2 ** THIRD_SH + 2) / 3;

  // Register values after reset and what follows from them
  localparam int ROW_BYTES_RST = 1920;
  localparam int WIDTH_RST     = 640;
  localparam int HEIGHT_RST    = 480;
  localparam int STRIDE_RST    = (ROW_BYTES_RST < MIN_STRIDE) ? MIN_STRIDE :
                                 (ROW_BYTES_RST > MAX_ROW_BYTES) ? MAX_ROW_BYTES :
                                 ROW_BYTES_RST;
  localparam int W_RST         = (WIDTH_RST < STRIDE_RST / 3) ? WIDTH_RST : STRIDE_RST / 3;
  localparam int SIG_RST       = PIX_BYTES * W_RST;
  localparam int TOTAL_RST     = STRIDE_RST * HEIGHT_RST;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_BYTES   = 2'd0,
    REG_WIDTH_PX    = 2'd1,
    REG_HEIGHT_ROWS = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_COPY,
    MODE_ZERO,
    MODE_KERNEL
  } mode_e;

  // Per-beat control that travels down the pipe
  typedef struct packed {
    logic  emit;
    mode_e mode;
    logic  last;
  } ctl_t;

  // Image geometry derived from the registers
  typedef struct packed {
    logic [RB_W-1:0]    stride;
    logic [ROW_W-1:0]   height;
    logic [RB_W-1:0]    sig;
    logic [RB_W-1:0]    sig_m3;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] total_m1;
  } geom_t;

  // Recompute status and re-derived output position
  typedef struct packed {
    logic             busy;
    logic             load;
    logic [ROW_W-1:0] orow;
    logic [RB_W-1:0]  ocol;
  } sync_t;

  // Kernel operands
  typedef struct packed {
    logic [BYTE_W-1:0] center;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] right;
    logic [BYTE_W-1:0] above;
    logic [BYTE_W-1:0] below;
  } win_t;

endpackage

// File: hdl/shp_cfg.sv
// Config registers, derived geometry and output-position re-derivation.
`timescale 1ns / 1ps

module shp_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [shp_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [shp_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [shp_pkg::TOTAL_W-1:0]  emit_cnt_i,
  output shp_pkg::geom_t               geom_o,
  output shp_pkg::sync_t               sync_o
);
  import shp_pkg::*;

  localparam int IT_W   = $clog2(TOTAL_W);
  localparam int PROD_W = RB_W + THIRD_SH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_TOTAL,
    ST_THIRD,
    ST_SIG,
    ST_DIV,
    ST_LOAD
  } state_e;

  state_e             state_q;
  logic [RB_W-1:0]    row_bytes_q;
  logic [WID_W-1:0]   width_q;
  logic [ROW_W-1:0]   height_q;
  logic [RB_W-1:0]    stride_q;
  logic [WID_W-1:0]   w_q;
  logic [RB_W-1:0]    sig_q;
  logic [RB_W-1:0]    sig_m3_q;
  logic [TOTAL_W-1:0] total_q;
  logic [TOTAL_W-1:0] total_m1_q;
  logic [IT_W-1:0]    it_q;
  logic [RB_W-1:0]    rem_q;
  logic [TOTAL_W-1:0] quo_q;

  logic                 wr;
  logic [RB_W-1:0]      stride_d;
  logic [TOTAL_W-1:0]   area;
  logic [PROD_W-1:0]    third_prod;
  logic [WID_W-1:0]     third;
  logic [WID_W-1:0]     w_d;
  logic [RB_W:0]        rem_sh;
  logic                 ge;
  logic [RB_W:0]        rem_sub;

  assign wr = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    stride_d = row_bytes_q;
    if (row_bytes_q < RB_W'(MIN_STRIDE)) begin
      stride_d = RB_W'(MIN_STRIDE);
    end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
      stride_d = RB_W'(MAX_ROW_BYTES);
    end
  end

  assign area       = TOTAL_W'(stride_q) * TOTAL_W'(height_q);
  assign third_prod = PROD_W'(stride_q) * PROD_W'(THIRD_MUL);
  assign third      = third_prod[THIRD_SH +: WID_W];
  assign w_d        = (width_q < third) ? width_q : third;

  // one restoring shift-subtract step per cycle
  assign rem_sh  = {rem_q, quo_q[TOTAL_W-1]};
  assign ge      = rem_sh >= {1'b0, stride_q};
  assign rem_sub = rem_sh - {1'b0, stride_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_bytes_q <= RB_W'(ROW_BYTES_RST);
      width_q     <= WID_W'(WIDTH_RST);
      height_q    <= ROW_W'(HEIGHT_RST);
      stride_q    <= RB_W'(STRIDE_RST);
      w_q         <= WID_W'(W_RST);
      sig_q       <= RB_W'(SIG_RST);
      sig_m3_q    <= RB_W'(SIG_RST - PIX_BYTES);
      total_q     <= TOTAL_W'(TOTAL_RST);
      total_m1_q  <= TOTAL_W'(TOTAL_RST - 1);
      it_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
    end else if (wr) begin
      state_q <= ST_CLAMP;
      unique case (cfg_index_i)
        REG_ROW_BYTES:   row_bytes_q <= cfg_data_i[RB_W-1:0];
        REG_WIDTH_PX:    width_q     <= cfg_data_i[WID_W-1:0];
        REG_HEIGHT_ROWS: height_q    <= cfg_data_i[ROW_W-1:0];
        default:         ;
      endcase
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_CLAMP: begin
          stride_q <= stride_d;
          state_q  <= ST_TOTAL;
        end
        ST_TOTAL: begin
          total_q <= area;
          state_q <= ST_THIRD;
        end
        ST_THIRD: begin
          w_q        <= w_d;
          total_m1_q <= total_q - TOTAL_W'(1);
          state_q    <= ST_SIG;
        end
        ST_SIG: begin
          sig_q    <= RB_W'({w_q, 1'b0}) + RB_W'(w_q);
          sig_m3_q <= RB_W'({w_q, 1'b0}) + RB_W'(w_q) - RB_W'(PIX_BYTES);
          quo_q    <= emit_cnt_i;
          rem_q    <= '0;
          it_q     <= '0;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= ge ? rem_sub[RB_W-1:0] : rem_sh[RB_W-1:0];
          quo_q <= {quo_q[TOTAL_W-2:0], ge};
          it_q  <= it_q + IT_W'(1);
          if (it_q == IT_W'(TOTAL_W - 1)) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign geom_o.stride   = stride_q;
  assign geom_o.height   = height_q;
  assign geom_o.sig      = sig_q;
  assign geom_o.sig_m3   = sig_m3_q;
  assign geom_o.total    = total_q;
  assign geom_o.total_m1 = total_m1_q;

  assign sync_o.busy = state_q != ST_IDLE;
  assign sync_o.load = state_q == ST_LOAD;
  assign sync_o.orow = (|quo_q[TOTAL_W-1:ROW_W]) ? '1 : quo_q[ROW_W-1:0];
  assign sync_o.ocol = rem_q;

endmodule

// File: hdl/shp_ctrl.sv
// Input and output position counters; classifies each beat at the front.
`timescale 1ns / 1ps

module shp_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         open_i,
  input  logic                         req_type_i,
  input  logic [shp_pkg::BYTE_W-1:0]   pixel_byte_i,
  input  shp_pkg::geom_t               geom_i,
  input  shp_pkg::sync_t               sync_i,
  output logic                         push_o,
  output logic [shp_pkg::ADDR_W-1:0]   idx_o,
  output logic [shp_pkg::BYTE_W-1:0]   x_o,
  output shp_pkg::ctl_t                ctl_o,
  output logic [shp_pkg::TOTAL_W-1:0]  emit_cnt_o
);
  import shp_pkg::*;

  logic [RB_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [TOTAL_W-1:0] emit_q;
  logic [RB_W-1:0]    ocol_q, ocol_d;
  logic [ROW_W-1:0]   orow_q, orow_d;

  logic          input_done;
  logic          started;
  logic          emit;
  logic          is_last;
  logic [RB_W:0] col_inc;
  logic [RB_W:0] ocol_inc;
  logic          copy_row;
  mode_e         mode;

  always_comb begin
    input_done = row_q >= geom_i.height;
    push_o     = in_valid_i && open_i && !(req_type_i && !input_done);
    x_o        = input_done ? '0 : pixel_byte_i;
    idx_o      = ADDR_W'(col_q);

    col_inc = {1'b0, col_q} + (RB_W+1)'(1);
    if (col_inc >= {1'b0, geom_i.stride}) begin
      col_d = '0;
      row_d = (row_q != '1) ? row_q + ROW_W'(1) : row_q;
    end else begin
      col_d = col_inc[RB_W-1:0];
      row_d = row_q;
    end

    // first result waits until the center tap holds row 0, byte 0
    if (row_q == '0) begin
      started = {1'b0, col_q} >= {1'b0, geom_i.stride} + (RB_W+1)'(CTR_TAP);
    end else if (row_q == ROW_W'(1)) begin
      started = col_q >= RB_W'(CTR_TAP);
    end else begin
      started = 1'b1;
    end
    emit    = (emit_q != '0 || started) && emit_q < geom_i.total;
    is_last = emit_q == geom_i.total_m1;

    ocol_inc = {1'b0, ocol_q} + (RB_W+1)'(1);
    if (ocol_inc >= {1'b0, geom_i.stride}) begin
      ocol_d = '0;
      orow_d = orow_q + ROW_W'(1);
    end else begin
      ocol_d = ocol_inc[RB_W-1:0];
      orow_d = orow_q;
    end

    copy_row = orow_q == '0 ||
               ({1'b0, orow_q} + (ROW_W+1)'(1)) >= {1'b0, geom_i.height};
    if (copy_row) begin
      mode = MODE_COPY;
    end else if (ocol_q >= geom_i.sig) begin
      mode = MODE_ZERO;
    end else if (ocol_q < RB_W'(PIX_BYTES) || ocol_q >= geom_i.sig_m3) begin
      mode = MODE_COPY;    // edge pixels
    end else begin
      mode = MODE_KERNEL;
    end

    ctl_o.emit = emit;
    ctl_o.mode = mode;
    ctl_o.last = emit && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else if (sync_i.load) begin
      ocol_q <= sync_i.ocol;
      orow_q <= sync_i.orow;
    end else if (push_o) begin
      if (emit && is_last) begin
        col_q  <= '0;
        row_q  <= '0;
        emit_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        col_q <= col_d;
        row_q <= row_d;
        if (emit) begin
          emit_q <= emit_q + TOTAL_W'(1);
          ocol_q <= ocol_d;
          orow_q <= orow_d;
        end
      end
    end
  end

  assign emit_cnt_o = emit_q;

endmodule

// File: hdl/shp_line.sv
// Two line buffers and the 3-row tap window (pipe stages 1 and 2).
`timescale 1ns / 1ps

module shp_line (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       push_i,
  input  logic [shp_pkg::ADDR_W-1:0] idx_i,
  input  logic [shp_pkg::BYTE_W-1:0] x_i,
  input  shp_pkg::ctl_t              ctl_i,
  output logic                       s2_valid_o,
  output shp_pkg::ctl_t              s2_ctl_o,
  output shp_pkg::win_t              win_o
);
  import shp_pkg::*;

  logic [BYTE_W-1:0] newer_mem [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] older_mem [MAX_ROW_BYTES];

  logic [BYTE_W-1:0] nrd_q;     // one row back
  logic [BYTE_W-1:0] ord_q;     // two rows back
  logic              s1_v_q;
  logic [BYTE_W-1:0] s1_x_q;
  logic [ADDR_W-1:0] s1_idx_q;
  ctl_t              s1_ctl_q;
  logic              s2_v_q;
  ctl_t              s2_ctl_q;

  logic [CTR_TAP:0][BYTE_W-1:0]  live_q;
  logic [TAP_SPAN-1:0][BYTE_W-1:0] mid_q;
  logic [CTR_TAP:0][BYTE_W-1:0]  top_q;

  // read-first on newer; older gets the displaced byte when stage 1 advances
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      nrd_q            <= newer_mem[idx_i];
      ord_q            <= older_mem[idx_i];
      newer_mem[idx_i] <= x_i;
    end
    if (adv_i && s1_v_q) begin
      older_mem[s1_idx_q] <= nrd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_x_q   <= x_i;
      s1_idx_q <= idx_i;
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      live_q <= '0;
      mid_q  <= '0;
      top_q  <= '0;
    end else if (adv_i) begin
      s1_v_q <= push_i;
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        live_q <= {live_q[CTR_TAP-1:0], s1_x_q};
        mid_q  <= {mid_q[TAP_SPAN-2:0], nrd_q};
        top_q  <= {top_q[CTR_TAP-1:0], ord_q};
      end
    end
  end

  assign s2_valid_o   = s2_v_q;
  assign s2_ctl_o     = s2_ctl_q;
  assign win_o.center = mid_q[CTR_TAP];
  assign win_o.left   = mid_q[TAP_SPAN-1];
  assign win_o.right  = mid_q[0];
  assign win_o.above  = top_q[CTR_TAP];
  assign win_o.below  = live_q[CTR_TAP];

endmodule

// File: hdl/shp_kern.sv
// Cross kernel arithmetic, clamp and output select (pipe stages 3 and 4).
`timescale 1ns / 1ps

module shp_kern (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       s2_valid_i,
  input  shp_pkg::ctl_t              s2_ctl_i,
  input  shp_pkg::win_t              win_i,
  output logic                       s4_valid_o,
  output logic [shp_pkg::BYTE_W-1:0] s4_byte_o,
  output logic                       s4_last_o
);
  import shp_pkg::*;

  localparam int C5_W  = BYTE_W + 3;
  localparam int NB_W  = BYTE_W + 2;
  localparam int DIF_W = C5_W + 1;

  logic              s3_v_q;
  ctl_t              s3_ctl_q;
  logic [C5_W-1:0]   c5_q;
  logic [NB_W-1:0]   nb_q;
  logic [BYTE_W-1:0] ctr_q;
  logic              s4_v_q;
  logic [BYTE_W-1:0] s4_byte_q;
  logic              s4_last_q;

  logic signed [DIF_W-1:0] diff;
  logic [BYTE_W-1:0]       clamped;
  logic [BYTE_W-1:0]       sel;

  always_comb begin
    diff = $signed({1'b0, c5_q}) - $signed({{(DIF_W-NB_W){1'b0}}, nb_q});
    if (diff[DIF_W-1]) begin
      clamped = '0;
    end else if (|diff[DIF_W-2:BYTE_W]) begin
      clamped = '1;
    end else begin
      clamped = diff[BYTE_W-1:0];
    end
    case (s3_ctl_q.mode)
      MODE_ZERO:   sel = '0;
      MODE_KERNEL: sel = clamped;
      default:     sel = ctr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_ctl_q  <= s2_ctl_i;
      c5_q      <= C5_W'(win_i.center) * C5_W'(CTR_GAIN);
      nb_q      <= NB_W'(win_i.left) + NB_W'(win_i.right) +
                   NB_W'(win_i.above) + NB_W'(win_i.below);
      ctr_q     <= win_i.center;
      s4_byte_q <= sel;
      s4_last_q <= s3_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (adv_i) begin
      s3_v_q <= s2_valid_i;
      s4_v_q <= s3_v_q && s3_ctl_q.emit;
    end
  end

  assign s4_valid_o = s4_v_q;
  assign s4_byte_o  = s4_byte_q;
  assign s4_last_o  = s4_last_q;

endmodule

// File: hdl/sharpen_3x3_rgb_stream.sv
// Top level: 3x3 cross sharpen over a BGR byte stream of padded rows.
`timescale 1ns / 1ps

// Streams the pixel array of a BGR image one byte per beat in raster order
// and returns the sharpened bytes in the same order: each interior byte becomes
// 5*center minus the same channel one pixel left, right, up and down, clamped
// to 0..255. Top and bottom rows pass through, the first and last pixel of each
// interior row are copied, and row padding past 3*min(width_px, S/3) is zeroed,
// S being row_bytes clamped to 3..6144. Output byte k is released by input beat
// k + S + 3, so after the last image byte send S + 3 drain beats (req_type
// = 1); a drain beat that arrives before the image is complete is swallowed
// with no result. last_of_image flags the final byte, after which the next
// beat starts a new image. Throughput is one beat per clock in and out when
// unstalled; a released result reaches out_byte_o through four pipe stages
// (line buffer read, tap window, kernel sums, clamp/select) and a two-entry
// output queue that lets input run while one result waits. Each config write
// holds in_stall_o high while the stride-derived values are rebuilt and the
// output position is re-derived by a 29-step shift-subtract divider.
module sharpen_3x3_rgb_stream (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input beats
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [shp_pkg::BYTE_W-1:0]    pixel_byte_i,
  // output beats
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [shp_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          last_of_image_o,
  // config writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [shp_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [shp_pkg::CFG_W-1:0]     cfg_data_i
);
  import shp_pkg::*;

  geom_t              geom;
  sync_t              sync;
  logic [TOTAL_W-1:0] emit_cnt;

  logic              adv;       // whole pipe moves together
  logic              open;
  logic              push;
  logic [ADDR_W-1:0] idx;
  logic [BYTE_W-1:0] x;
  ctl_t              ctl;
  logic              s2_valid;
  ctl_t              s2_ctl;
  win_t              win;
  logic              s4_valid;
  logic [BYTE_W-1:0] s4_byte;
  logic              s4_last;

  // two-entry output queue
  logic [1:0]        cnt_q;
  logic [BYTE_W-1:0] e0_byte_q, e1_byte_q;
  logic              e0_last_q, e1_last_q;
  logic              q_push, q_take;

  assign adv        = cnt_q != 2'd2;
  assign open       = adv && !sync.busy;
  assign in_stall_o = !open;

  shp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .emit_cnt_i  (emit_cnt),
    .geom_o      (geom),
    .sync_o      (sync)
  );

  shp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .open_i       (open),
    .req_type_i   (req_type_i),
    .pixel_byte_i (pixel_byte_i),
    .geom_i       (geom),
    .sync_i       (sync),
    .push_o       (push),
    .idx_o        (idx),
    .x_o          (x),
    .ctl_o        (ctl),
    .emit_cnt_o   (emit_cnt)
  );

  shp_line u_line (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .push_i     (push),
    .idx_i      (idx),
    .x_i        (x),
    .ctl_i      (ctl),
    .s2_valid_o (s2_valid),
    .s2_ctl_o   (s2_ctl),
    .win_o      (win)
  );

  shp_kern u_kern (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .s2_valid_i (s2_valid),
    .s2_ctl_i   (s2_ctl),
    .win_i      (win),
    .s4_valid_o (s4_valid),
    .s4_byte_o  (s4_byte),
    .s4_last_o  (s4_last)
  );

  assign q_push = adv && s4_valid;
  assign q_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (q_push && !q_take) begin
      cnt_q <= cnt_q + 2'd1;
    end else if (!q_push && q_take) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // head is e0; e1 only fills while the head is held
  always_ff @(posedge clk_i) begin
    if (q_take) begin
      if (cnt_q == 2'd2) begin
        e0_byte_q <= e1_byte_q;
        e0_last_q <= e1_last_q;
        if (q_push) begin
          e1_byte_q <= s4_byte;
          e1_last_q <= s4_last;
        end
      end else if (q_push) begin
        e0_byte_q <= s4_byte;
        e0_last_q <= s4_last;
      end
    end else if (q_push) begin
      if (cnt_q == 2'd0) begin
        e0_byte_q <= s4_byte;
        e0_last_q <= s4_last;
      end else begin
        e1_byte_q <= s4_byte;
        e1_last_q <= s4_last;
      end
    end
  end

  assign out_valid_o     = cnt_q != 2'd0;
  assign out_byte_o      = e0_byte_q;
  assign last_of_image_o = e0_last_q;

endmodule

// File: sim/sharpen_checker.sv
// Checker for the sharpen stream: tracks beats and register writes, predicts and compares.
`timescale 1ns / 1ps

module sharpen_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          req_type_i,
  input  logic [shp_pkg::BYTE_W-1:0]    pixel_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [shp_pkg::BYTE_W-1:0]    out_byte_i,
  input  logic                          last_of_image_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [shp_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [shp_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            err_count_o,
  output int                            pending_o,
  output int                            checked_o
);
  import shp_pkg::*;

  localparam int SPAN = TAP_SPAN;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } sharp_beat_t;

  logic [RB_W-1:0]   row_bytes_q;
  logic [WID_W-1:0]  width_q;
  logic [ROW_W-1:0]  height_q;

  logic [BYTE_W-1:0] older_line [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] newer_line [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] live_taps  [SPAN];   // current stream
  logic [BYTE_W-1:0] up1_taps   [SPAN];   // one row back
  logic [BYTE_W-1:0] up2_taps   [SPAN];   // two rows back

  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned sent_bytes;

  sharp_beat_t sharpened_q [$];
  sharp_beat_t want;
  int errs = 0;
  int checked = 0;

  function automatic void clear_state();
    row_bytes_q = RB_W'(ROW_BYTES_RST);
    width_q     = WID_W'(WIDTH_RST);
    height_q    = ROW_W'(HEIGHT_RST);
    for (int i = 0; i < MAX_ROW_BYTES; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int j = 0; j < SPAN; j++) begin
      live_taps[j] = '0;
      up1_taps[j]  = '0;
      up2_taps[j]  = '0;
    end
    col_pos    = 0;
    row_pos    = 0;
    sent_bytes = 0;
    sharpened_q.delete();
  endfunction

  // One accepted input beat: advance the line buffers and window, queue the
  // sharpened byte it releases, if any.
  function automatic void sharpen_byte_in(input logic drain, input logic [BYTE_W-1:0] pix);
    int unsigned stride, rows, total, t, k, row, col, w, sig, px, idx;
    logic in_done;
    logic [BYTE_W-1:0] x, d1, d2, val;
    int acc;
    stride = row_bytes_q;
    if (stride < MIN_STRIDE) stride = MIN_STRIDE;
    if (stride > MAX_ROW_BYTES) stride = MAX_ROW_BYTES;
    rows    = height_q;
    total   = stride * rows;
    in_done = row_pos >= rows;
    if (drain && !in_done) return;   // early drain is swallowed
    x   = in_done ? '0 : pix;
    t   = row_pos * stride + col_pos;
    idx = (col_pos < MAX_ROW_BYTES) ? col_pos : MAX_ROW_BYTES - 1;
    d1  = newer_line[idx];
    d2  = older_line[idx];
    older_line[idx] = d1;
    newer_line[idx] = x;
    for (int j = SPAN - 1; j > 0; j--) begin
      live_taps[j] = live_taps[j-1];
      up1_taps[j]  = up1_taps[j-1];
      up2_taps[j]  = up2_taps[j-1];
    end
    live_taps[0] = x;
    up1_taps[0]  = d1;
    up2_taps[0]  = d2;
    if (col_pos + 1 >= stride) begin
      col_pos = 0;
      if (row_pos < 16'hFFFF) row_pos++;
    end else begin
      col_pos++;
    end

    if (!(sent_bytes > 0 || t >= stride + 3) || sent_bytes >= total) return;

    k   = sent_bytes;
    row = k / stride;
    col = k % stride;
    w   = width_q;
    if (w > stride / 3) w = stride / 3;
    sig = 3 * w;
    if (row == 0 || row + 1 >= rows) begin
      val = up1_taps[CTR_TAP];
    end else if (col >= sig) begin
      val = '0;
    end else begin
      px = col / 3;
      if (px == 0 || px + 1 == w) begin
        val = up1_taps[CTR_TAP];
      end else begin
        acc = CTR_GAIN * int'(up1_taps[CTR_TAP]) - int'(up1_taps[SPAN-1])
              - int'(up1_taps[0]) - int'(up2_taps[CTR_TAP]) - int'(live_taps[CTR_TAP]);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        val = acc[BYTE_W-1:0];
      end
    end
    sharpened_q.push_back('{value: val, last: (k + 1 == total)});
    sent_bytes++;
    if (k + 1 == total) begin
      col_pos    = 0;
      row_pos    = 0;
      sent_bytes = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ROW_BYTES:   row_bytes_q = cfg_data_i[RB_W-1:0];
          REG_WIDTH_PX:    width_q     = cfg_data_i[WID_W-1:0];
          REG_HEIGHT_ROWS: height_q    = cfg_data_i[ROW_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) sharpen_byte_in(req_type_i, pixel_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (sharpened_q.size() == 0) begin
          if (errs < MAX_REPORTS)
            $display("[%0t] unexpected result: byte %0d last %0b", $realtime,
                     out_byte_i, last_of_image_i);
          errs++;
        end else begin
          want = sharpened_q.pop_front();
          if (out_byte_i !== want.value || last_of_image_i !== want.last) begin
            if (errs < MAX_REPORTS)
              $display("[%0t] result %0d mismatch: expected byte %0d last %0b, got %0d last %0b",
                       $realtime, checked, want.value, want.last, out_byte_i, last_of_image_i);
            errs++;
          end
        end
        checked++;
      end
    end
    err_count_o <= errs;
    pending_o   <= sharpened_q.size();
    checked_o   <= checked;
  end

endmodule

// File: sim/testbench.sv
// Bench top for the sharpen stream: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module testbench;
  import shp_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 9;
  // Give the pipe and output queue extra room before register writes and
  // before the verdict.
  localparam int SETTLE_CYCLES = 16;
  // Slowest run: ~1.2k beats under source gaps and sink stalls, plus a few
  // dozen register updates. Taken many times over.
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_BEATS  = 750;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic              req_type   = 1'b0;
  logic [BYTE_W-1:0] pixel_byte = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  reg_idx_e          cfg_index  = REG_ROW_BYTES;
  logic [CFG_W-1:0]  cfg_data   = '0;

  int err_count;
  int pending;
  int checked;
  int cycle_count  = 0;
  int beats_sent   = 0;
  int images_done  = 0;
  int geometries   = 0;
  int random_beats = 0;
  bit calm         = 1'b0;   // no source gaps while set
  int stall_pct    = 0;      // chance per clock that the sink starts a stall
  int stall_left   = 0;

  // geometry last written, as raw register data
  logic [CFG_W-1:0] cur_rb;
  logic [CFG_W-1:0] cur_w;
  logic [CFG_W-1:0] cur_h;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sharpen_3x3_rgb_stream DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .pixel_byte_i   (pixel_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte),
    .last_of_image_o(out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  sharpen_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .pixel_byte_i   (pixel_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_byte_i     (out_byte),
    .last_of_image_i(out_last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sink side: random stall bursts, now and then a long one.
  // stall_pct = 0 gives stretches where the sink takes every result at once.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(11) == 0) ? $urandom_range(30, 10) : $urandom_range(2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Source gap before a beat: mostly none, some short, a few long.
  function automatic int idle_len();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Pixel data leans toward 0 and 255 so the clamp is hit from both sides.
  function automatic logic [BYTE_W-1:0] next_byte();
    logic [31:0] raw;
    raw = $urandom;
    case (raw[31:29])
      3'd0:    return 8'h00;
      3'd1:    return 8'hFF;
      default: return raw[BYTE_W-1:0];
    endcase
  endfunction

  // Stride the block actually uses for a given register write.
  function automatic int stride_of(input logic [CFG_W-1:0] rb);
    int s;
    s = rb[RB_W-1:0];
    if (s < MIN_STRIDE) s = MIN_STRIDE;
    if (s > MAX_ROW_BYTES) s = MAX_ROW_BYTES;
    return s;
  endfunction

  // One input beat; valid stays high into the next beat unless a gap is drawn.
  task automatic send_beat(input logic drain, input logic [BYTE_W-1:0] value);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    req_type   <= drain;
    pixel_byte <= value;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic park_input();
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted result is out, then let the pipe go quiet.
  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write beat; valid is left high so writes can run back to back.
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Registers only change with the block idle: no input, nothing in flight.
  task automatic set_geometry(input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h);
    park_input();
    wait_drained();
    write_reg(REG_ROW_BYTES, rb);
    write_reg(REG_WIDTH_PX, w);
    write_reg(REG_HEIGHT_ROWS, h);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    cur_rb = rb;
    cur_w  = w;
    cur_h  = h;
    geometries++;
  endtask

  // Full image: stride*height image bytes with swallowed early drains mixed
  // in, then stride+3 flush beats of either type. hold_mid parks the source
  // halfway until every result released so far has come out.
  task automatic run_image(input bit hold_mid);
    int stride;
    int body;
    stride = stride_of(cur_rb);
    body   = stride * cur_h;
    for (int i = 0; i < body; i++) begin
      if (hold_mid && i == body / 2) begin
        park_input();
        while (pending != 0) @(posedge clk_i);
      end
      if (i == 0 || $urandom_range(24) == 0) send_beat(1'b1, next_byte());
      send_beat(1'b0, next_byte());
    end
    // after the last image byte, image bytes count as drain ticks
    for (int i = 0; i < stride + 3; i++) send_beat($urandom_range(1) == 1, next_byte());
    images_done++;
  endtask

  initial begin
    int roll;
    int failures;
    logic [CFG_W-1:0] rb;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: small images covering each geometry corner.
    stall_pct = 20;
    set_geometry(16'd0, 16'd1, 16'd3);    // stride under 3 saturates, one-pixel rows
    run_image(1'b0);
    set_geometry(16'd12, 16'd0, 16'd3);   // zero width: interior rows are all padding
    run_image(1'b0);
    set_geometry(16'd7, 16'd5, 16'd4);    // width past stride/3, odd stride
    run_image(1'b1);
    set_geometry(16'd9, 16'd3, 16'd1);    // single row, copied through
    run_image(1'b0);
    set_geometry(16'd9, 16'd3, 16'd2);    // two rows, both copied; back-to-back images
    run_image(1'b0);
    run_image(1'b0);
    set_geometry(16'd16, 16'd5, 16'd5);   // regular image with padding
    run_image(1'b1);

    // Random geometries; half the time the same geometry runs again at once.
    while (random_beats < RANDOM_BEATS) begin
      calm      = ($urandom_range(3) == 0);
      stall_pct = calm ? 0 : $urandom_range(50, 5);
      if ($urandom_range(1) == 0) begin
        roll = $urandom_range(9);
        if (roll == 0) rb = $urandom_range(2);
        else if (roll == 1) rb = $urandom_range(64, 37);
        else rb = $urandom_range(36, 3);
        w = $urandom_range(stride_of(rb) / 3 + 2);
        h = $urandom_range(8, 1);
        set_geometry(rb, w, h);
      end
      random_beats += stride_of(cur_rb) * (cur_h + 1) + 3;
      run_image($urandom_range(7) == 0);
    end

    // Zero height: beats of either type are taken and nothing comes out.
    calm      = 1'b0;
    stall_pct = 20;
    set_geometry(16'd5, 16'd1, 16'd0);
    repeat (24) send_beat($urandom_range(1) == 1, next_byte());

    park_input();
    wait_drained();

    failures = err_count + pending;
    if (pending != 0) $display("%0d expected results never arrived", pending);
    $display("Ran %0d images over %0d register settings: %0d beats in, %0d results checked,",
             images_done, geometries, beats_sent, checked);
    $display("incl. clamped stride, oversized and zero width, short images and zero height.");
    if (failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sharpen_3x3_rgb_stream.f
hdl/shp_pkg.sv
hdl/shp_cfg.sv
hdl/shp_ctrl.sv
hdl/shp_line.sv
hdl/shp_kern.sv
hdl/sharpen_3x3_rgb_stream.sv
sim/sharpen_checker.sv
sim/testbench.sv
